// File: rtl/core/lkvc_pkg.sv
// Shared sizes, codes and types of the LRU key/value cache.
package lkvc_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W       = 5;
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int WORD_W      = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// request codes
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef logic [WORD_W-1:0]      word_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [CAP_W-1:0]       cap_t;
	typedef logic [MAX_ENTRIES-1:0] ent_vec_t;

	// lookup status handed from the search logic to the update logic
	typedef struct packed {
		ent_vec_t match_vec;
		logic     hit;
		idx_t     hit_idx;
		logic     free_any;
		idx_t     free_idx;
		logic     lru_any;
		idx_t     lru_idx;
	} lookup_t;

endpackage

// File: rtl/core/lkvc_lookup.sv
// Parallel key search, first free slot and least recent slot of the cache.
module lkvc_lookup (
	input  lkvc_pkg::word_t   key,
	input  lkvc_pkg::ent_vec_t valid,
	input  lkvc_pkg::word_t   keys [lkvc_pkg::MAX_ENTRIES],
	input  lkvc_pkg::idx_t    ranks [lkvc_pkg::MAX_ENTRIES],
	input  lkvc_pkg::cnt_t    count,
	output lkvc_pkg::lookup_t status
);
	import lkvc_pkg::*;

	ent_vec_t match_vec;
	ent_vec_t free_vec;
	ent_vec_t lru_vec;

	// compare every valid slot against the key; the oldest rank is count - 1
	always_comb begin
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			match_vec[i] = valid[i] && (keys[i] == key);
			free_vec[i]  = !valid[i];
			lru_vec[i]   = valid[i] && (CNT_W'(ranks[i]) == (count - cnt_t'(1)));
		end
	end

	// encode each vector, lowest slot wins
	always_comb begin
		status           = '0;
		status.match_vec = match_vec;
		status.hit       = |match_vec;
		status.free_any  = |free_vec;
		status.lru_any   = |lru_vec;
		for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
			if (match_vec[i]) begin
				status.hit_idx = IDX_W'(i);
			end
			if (free_vec[i]) begin
				status.free_idx = IDX_W'(i);
			end
			if (lru_vec[i]) begin
				status.lru_idx = IDX_W'(i);
			end
		end
	end

endmodule

// File: rtl/core/lru_key_value_cache.sv
// Top level of the fully associative key/value cache with LRU replacement.
//
//  channel   direction  handshake              payload
//  cfg       in         cfg_we                 cfg_wdata (capacity)
//  in        in         in_valid / in_ready    opcode, key, write_value
//  out       out        out_valid / out_ready  found, read_value, evicted,
//                                              hit_total, access_total
//
// A request is captured in an input register and resolved from there (key search,
// LRU rank update and counters) into the result register, one request per cycle
// sustained while out_ready is high.
// The result register holds while out_ready is low; the input register then
// holds one more request and in_ready drops.
// Reset empties the cache, clears both counters and sets capacity to 16.
module lru_key_value_cache (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  lkvc_pkg::cap_t       cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 opcode,
	input  logic signed [31:0]   key,
	input  logic signed [31:0]   write_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 found,
	output logic signed [31:0]   read_value,
	output logic                 evicted,
	output logic [31:0]          hit_total,
	output logic [31:0]          access_total
);
	import lkvc_pkg::*;

	// configuration
	cap_t cap_q;

	// input stage
	logic  valid_s1;
	logic  opcode_s1;
	word_t key_s1;
	word_t wval_s1;
	logic  advance;

	// cache state
	ent_vec_t valid_q;
	idx_t     rank_q [MAX_ENTRIES];
	word_t    keys_q [MAX_ENTRIES];
	word_t    vals_q [MAX_ENTRIES];
	cnt_t     count_q;
	word_t    hits_q;
	word_t    acc_q;

	// next state
	ent_vec_t valid_d;
	idx_t     rank_d [MAX_ENTRIES];
	cnt_t     count_d;
	word_t    hits_d;
	word_t    acc_d;
	logic     val_we;
	logic     key_we;
	idx_t     wr_idx;
	logic     found_d;
	word_t    rval_d;
	logic     evict_d;

	// result register
	logic  out_valid_q;
	logic  found_q;
	word_t rval_q;
	logic  evict_q;

	lookup_t          lk;
	logic [CMP_W-1:0] eff_cap;
	logic             room;
	idx_t             slot;
	idx_t             prom_rank;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// capture the request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			key_s1    <= key;
			wval_s1   <= write_value;
		end
	end

	lkvc_lookup u_lookup (
		.key    (key_s1),
		.valid  (valid_q),
		.keys   (keys_q),
		.ranks  (rank_q),
		.count  (count_q),
		.status (lk)
	);

	// clamp capacity to 1 .. MAX_ENTRIES
	always_comb begin
		eff_cap = CMP_W'(cap_q);
		if (eff_cap == '0) begin
			eff_cap = CMP_W'(1);
		end else if (eff_cap > CMP_W'(MAX_ENTRIES)) begin
			eff_cap = CMP_W'(MAX_ENTRIES);
		end
	end

	assign room      = (CMP_W'(count_q) < eff_cap) && lk.free_any;
	assign slot      = room ? lk.free_idx : lk.lru_idx;
	assign prom_rank = rank_q[lk.hit_idx];

	// resolve the request: hit, update or insert with eviction
	always_comb begin
		valid_d = valid_q;
		rank_d  = rank_q;
		count_d = count_q;
		hits_d  = hits_q;
		acc_d   = acc_q;
		val_we  = 1'b0;
		key_we  = 1'b0;
		wr_idx  = lk.hit_idx;
		found_d = lk.hit;
		rval_d  = '0;
		evict_d = 1'b0;
		if (opcode_s1 == OP_GET) begin
			acc_d = (acc_q == '1) ? acc_q : acc_q + WORD_W'(1);
		end
		if (lk.hit) begin
			// promote the hit slot; younger entries age by one
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (valid_q[i] && (IDX_W'(i) != lk.hit_idx) && (rank_q[i] < prom_rank)) begin
					rank_d[i] = rank_q[i] + IDX_W'(1);
				end
			end
			rank_d[lk.hit_idx] = '0;
			if (opcode_s1 == OP_GET) begin
				rval_d = vals_q[lk.hit_idx];
				hits_d = (hits_q == '1) ? hits_q : hits_q + WORD_W'(1);
			end else begin
				val_we = 1'b1;
			end
		end else if (opcode_s1 == OP_PUT) begin
			// insert as most recent, reusing the least recent slot when full
			evict_d = !room && lk.lru_any;
			wr_idx  = slot;
			val_we  = 1'b1;
			key_we  = 1'b1;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				if (valid_q[i] && !(evict_d && (IDX_W'(i) == slot))) begin
					rank_d[i] = rank_q[i] + IDX_W'(1);
				end
			end
			valid_d[slot] = 1'b1;
			rank_d[slot]  = '0;
			count_d       = evict_d ? count_q : count_q + CNT_W'(1);
		end
	end

	// control state of the cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			hits_q  <= '0;
			acc_q   <= '0;
			for (int i = 0; i < MAX_ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			valid_q <= valid_d;
			count_q <= count_d;
			hits_q  <= hits_d;
			acc_q   <= acc_d;
			rank_q  <= rank_d;
		end
	end

	// key and value storage
	always_ff @(posedge clk) begin
		if (advance && val_we) begin
			vals_q[wr_idx] <= wval_s1;
		end
		if (advance && key_we) begin
			keys_q[wr_idx] <= key_s1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q <= found_d;
			rval_q  <= rval_d;
			evict_q <= evict_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign read_value   = rval_q;
	assign evicted      = evict_q;
	assign hit_total    = hits_q;
	assign access_total = acc_q;

	// the fill count tracks the valid bits
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("entry count disagrees with valid slots");

	// a key sits in at most one slot
	a_unique_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $onehot0(lk.match_vec))
		else $error("key present in more than one slot");

	// an eviction never reports the key as present
	a_evict_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && evict_q |-> !found_q)
		else $error("eviction on a hit");

	// a get hit bumps the hit counter unless saturated
	a_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && lk.hit && (opcode_s1 == OP_GET) && (hits_q != '1)
		|=> hits_q == $past(hits_q) + WORD_W'(1))
		else $error("hit counter missed a hit");

endmodule
